// ===== sv/xtid_pkg.sv =====
// shared types and codes for the xpm text image decoder
`timescale 1ns / 1ps
package xtid_pkg;

    typedef enum logic [1:0] {
        F_START = 2'd0,
        F_TEXT  = 2'd1,
        F_EOL   = 2'd2,
        F_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        K_STATUS  = 2'd0,
        K_PIXEL   = 2'd1,
        K_REFUSED = 2'd2
    } t_kind;

    localparam int MAX_SIDE   = 254;
    localparam int MAX_COLORS = 254;

    localparam logic [7:0]  NO_SYMBOL   = 8'hff;
    localparam logic [31:0] COLOR_NONE  = 32'hFF000000;
    localparam logic [31:0] COLOR_BLACK = 32'h00000000;
    localparam logic [31:0] COLOR_WHITE = 32'h00FFFFFF;

endpackage

// ===== sv/xtid_if.sv =====
// valid/ready channel interfaces for the input beats and the result beats
`timescale 1ns / 1ps
interface xtid_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] text_byte;
    modport source (output valid, output func, output text_byte, input ready);
    modport sink   (input valid, input func, input text_byte, output ready);
endinterface

interface xtid_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        image_ok;
    logic [31:0] pixel_color;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        last_pixel;
    modport source (output valid, output kind, output image_ok, output pixel_color,
                    output pixel_x, output pixel_y, output last_pixel, input ready);
    modport sink   (input valid, input kind, input image_ok, input pixel_color,
                    input pixel_x, input pixel_y, input last_pixel, output ready);
endinterface

// ===== sv/xtid_ram.sv =====
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps
module xtid_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/xpm_text_image_decoder.sv =====
// top level of the xpm text image decoder: parse sequencer and the three stores
// a text beat is accepted, then decided; a read beat is accepted with the pixel store read,
// then reads the palette, then loads the result register
// a new beat is taken only once the current beat's step is done, and a step that yields
// a result waits while the output register is still full
// reset: synchronous active low; clears the parse to the header phase, all symbol
// valid bits and the output valid flag; palette and pixel stores are not cleared
`timescale 1ns / 1ps
module xpm_text_image_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    xtid_in_if.sink    i_in,
    xtid_out_if.source o_out
);
    import xtid_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PALETTE, PH_PIXELS, PH_DONE, PH_FAILED
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE, S_EXEC, S_PAL
    } t_state;

    // sequencer and parse registers
    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_func;
    logic [7:0]  r_byte;
    logic [7:0]  r_hdr [4];
    logic [7:0]  n_hdr [4];
    logic [2:0]  r_fcnt, n_fcnt;
    logic        r_innum, n_innum;
    logic [7:0]  r_lpos, n_lpos;
    logic [7:0]  r_lcnt, n_lcnt;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_csym, n_csym;
    logic        r_hex, n_hex;
    logic [2:0]  r_mask, n_mask;
    logic [7:0]  r_rdx, n_rdx;
    logic [7:0]  r_rdy, n_rdy;
    logic [255:0] r_svld;
    logic        n_sclr;

    // output register
    logic        r_ovld;
    logic [1:0]  r_okind;
    logic        r_ook;
    logic [31:0] r_ocol;
    logic [7:0]  r_ox, r_oy;
    logic        r_olast;

    // store ports
    logic        w_acc_in;
    logic [7:0]  w_sym_q, w_sym;
    logic        w_sym_we;
    logic [7:0]  w_pix_q;
    logic        w_pix_we;
    logic        w_pal_we, w_pal_re;
    logic [31:0] w_pal_wd, w_pal_q;

    // decision helpers
    logic        w_res, w_ok, w_fail, w_busy, w_commit;
    logic [1:0]  w_kind;
    logic        w_digit, w_space;
    logic [1:0]  w_hidx;
    logic [11:0] w_prod;
    logic [4:0]  w_hexd;
    logic [7:0]  w_k;
    logic [2:0]  w_mnew;
    logic [31:0] w_color;
    logic        w_cok;
    logic [8:0]  w_lnext;

    function automatic logic [2:0] name_len(input int i);
        return (i == 0) ? 3'd4 : 3'd5;
    endfunction

    function automatic logic [7:0] name_chr(input int i, input logic [2:0] k);
        logic [7:0] c;
        c = 8'h00;
        case (i)
            0: c = (k == 3'd0) ? "N" : (k == 3'd1) ? "o" : (k == 3'd2) ? "n" : "e";
            1: c = (k == 3'd0) ? "B" : (k == 3'd1) ? "l" : (k == 3'd2) ? "a" :
                   (k == 3'd3) ? "c" : "k";
            default: c = (k == 3'd0) ? "W" : (k == 3'd1) ? "h" : (k == 3'd2) ? "i" :
                   (k == 3'd3) ? "t" : "e";
        endcase
        return c;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] d;
        d = 5'h10;
        if (b >= "0" && b <= "9") d = {1'b0, 4'(b - "0")};
        else if (b >= "a" && b <= "f") d = {1'b0, 4'(b - "a" + 8'd10)};
        else if (b >= "A" && b <= "F") d = {1'b0, 4'(b - "A" + 8'd10)};
        return d;
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc_in   = i_in.valid && i_in.ready;

    // a symbol with no valid bit reads as no symbol
    assign w_sym  = r_svld[r_byte] ? w_sym_q : NO_SYMBOL;
    assign w_busy = r_ovld && !o_out.ready;

    xtid_ram #(.ADDR_W(8), .DATA_W(8)) u_sym (
        .i_clk(i_clk), .i_we(w_sym_we), .i_waddr(r_csym), .i_wdata(r_lcnt),
        .i_re(w_acc_in), .i_raddr(i_in.text_byte), .o_rdata(w_sym_q)
    );

    xtid_ram #(.ADDR_W(16), .DATA_W(8)) u_pix (
        .i_clk(i_clk), .i_we(w_pix_we), .i_waddr({r_lcnt, r_lpos}), .i_wdata(w_sym),
        .i_re(w_acc_in), .i_raddr({r_rdy, r_rdx}), .o_rdata(w_pix_q)
    );

    xtid_ram #(.ADDR_W(8), .DATA_W(32)) u_pal (
        .i_clk(i_clk), .i_we(w_pal_we), .i_waddr(r_lcnt), .i_wdata(w_pal_wd),
        .i_re(w_pal_re), .i_raddr(w_pix_q), .o_rdata(w_pal_q)
    );

    // a beat's parse step: exec state once its symbol entry is back, S_PAL for reads
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_fcnt  = r_fcnt;
        n_innum = r_innum;
        n_lpos  = r_lpos;
        n_lcnt  = r_lcnt;
        n_acc   = r_acc;
        n_csym  = r_csym;
        n_hex   = r_hex;
        n_mask  = r_mask;
        n_rdx   = r_rdx;
        n_rdy   = r_rdy;
        n_sclr  = 1'b0;
        w_res   = 1'b0;
        w_ok    = 1'b0;
        w_kind  = K_STATUS;
        w_fail  = 1'b0;
        w_sym_we = 1'b0;
        w_pix_we = 1'b0;
        w_pal_we = 1'b0;
        w_pal_re = 1'b0;
        w_pal_wd = 32'h0;
        w_color = 32'h0;
        w_cok   = 1'b0;
        w_digit = (r_byte >= "0") && (r_byte <= "9");
        w_space = (r_byte == " ") || (r_byte >= 8'd9 && r_byte <= 8'd13);
        w_hidx  = r_innum ? 2'(r_fcnt - 3'd1) : r_fcnt[1:0];
        w_prod  = 12'(r_hdr[w_hidx]) * 12'd10 + 12'(r_byte - "0");
        w_hexd  = hex_val(r_byte);
        w_k     = (r_lpos == 8'd4) ? 8'd0 : 8'(r_lpos - 8'd4);
        w_lnext = 9'(r_lcnt) + 9'd1;
        for (int i = 0; i < 3; i++) begin
            w_mnew[i] = ((r_lpos == 8'd4) || r_mask[i]) && (w_k < 8'(name_len(i)))
                        && (name_chr(i, w_k[2:0]) == r_byte);
        end

        if (r_state == S_EXEC) begin
            n_state = S_IDLE;
            case (r_func)
                F_START: begin
                    n_sclr  = 1'b1;
                    n_phase = PH_HEADER;
                    n_hdr   = '{default: 8'd0};
                    n_fcnt  = 3'd0;
                    n_innum = 1'b0;
                    n_lpos  = 8'd0;
                    n_lcnt  = 8'd0;
                    n_acc   = 32'h0;
                    n_csym  = 8'd0;
                    n_hex   = 1'b0;
                    n_mask  = 3'd0;
                    n_rdx   = 8'd0;
                    n_rdy   = 8'd0;
                end
                F_READ: begin
                    if (r_phase == PH_DONE) begin
                        w_pal_re = 1'b1;
                        n_state  = S_PAL;
                    end else begin
                        w_res  = 1'b1;
                        w_kind = K_REFUSED;
                    end
                end
                F_TEXT: begin
                    case (r_phase)
                        PH_HEADER: begin
                            if (w_digit) begin
                                if (!r_innum && r_fcnt >= 3'd4) begin
                                    w_fail = 1'b1;
                                end else begin
                                    if (!r_innum) n_fcnt = r_fcnt + 3'd1;
                                    n_innum = 1'b1;
                                    n_hdr[w_hidx] = (w_prod > 12'd255) ? 8'd255 : w_prod[7:0];
                                end
                            end else if (w_space) begin
                                n_innum = 1'b0;
                            end else begin
                                w_fail = 1'b1;
                            end
                        end
                        PH_PALETTE: begin
                            if (r_byte == 8'd0) begin
                                w_fail = 1'b1;
                            end else if (r_lpos == 8'd0) begin
                                if (w_sym != NO_SYMBOL) w_fail = 1'b1;
                                n_csym = r_byte;
                            end else if (r_lpos == 8'd1 || r_lpos == 8'd3) begin
                                if (r_byte != " ") w_fail = 1'b1;
                            end else if (r_lpos == 8'd2) begin
                                if (r_byte != "c") w_fail = 1'b1;
                            end else if (r_lpos == 8'd4) begin
                                if (r_byte == "#") begin
                                    n_hex = 1'b1;
                                    n_acc = 32'h0;
                                end else begin
                                    n_hex  = 1'b0;
                                    n_mask = w_mnew;
                                    if (w_mnew == 3'd0) w_fail = 1'b1;
                                end
                            end else if (r_hex) begin
                                if (r_lpos > 8'd12 || w_hexd[4]) w_fail = 1'b1;
                                n_acc = {r_acc[27:0], w_hexd[3:0]};
                            end else begin
                                n_mask = w_mnew;
                                if (w_mnew == 3'd0) w_fail = 1'b1;
                            end
                            if (r_lpos < 8'd255) n_lpos = r_lpos + 8'd1;
                        end
                        PH_PIXELS: begin
                            if (r_lpos < r_hdr[0]) begin
                                if (w_sym == NO_SYMBOL) begin
                                    w_fail = 1'b1;
                                end else begin
                                    w_pix_we = 1'b1;
                                    n_lpos   = r_lpos + 8'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: begin
                    // end of line
                    case (r_phase)
                        PH_HEADER: begin
                            n_innum = 1'b0;
                            if (r_fcnt != 3'd4 || r_hdr[0] < 8'd1 || r_hdr[0] > 8'(MAX_SIDE)
                                || r_hdr[1] < 8'd1 || r_hdr[1] > 8'(MAX_SIDE)
                                || r_hdr[2] < 8'd2 || r_hdr[2] > 8'(MAX_COLORS)
                                || r_hdr[3] != 8'd1) begin
                                w_fail = 1'b1;
                            end else begin
                                n_phase = PH_PALETTE;
                                n_lcnt  = 8'd0;
                                n_lpos  = 8'd0;
                            end
                        end
                        PH_PALETTE: begin
                            if (r_hex) begin
                                w_color = r_acc;
                                w_cok   = (r_lpos == 8'd11) || (r_lpos == 8'd13);
                            end else begin
                                if (r_mask[0] && r_lpos == 8'd8) begin
                                    w_color = COLOR_NONE;
                                    w_cok   = 1'b1;
                                end
                                if (r_mask[1] && r_lpos == 8'd9) begin
                                    w_color = COLOR_BLACK;
                                    w_cok   = 1'b1;
                                end
                                if (r_mask[2] && r_lpos == 8'd9) begin
                                    w_color = COLOR_WHITE;
                                    w_cok   = 1'b1;
                                end
                            end
                            if (r_lpos < 8'd5 || !w_cok) begin
                                w_fail = 1'b1;
                            end else begin
                                w_pal_we = 1'b1;
                                w_pal_wd = w_color;
                                w_sym_we = 1'b1;
                                n_lpos   = 8'd0;
                                if (w_lnext >= 9'(r_hdr[2])) begin
                                    n_phase = PH_PIXELS;
                                    n_lcnt  = 8'd0;
                                end else begin
                                    n_lcnt = w_lnext[7:0];
                                end
                            end
                        end
                        PH_PIXELS: begin
                            if (r_lpos < r_hdr[0]) begin
                                w_fail = 1'b1;
                            end else begin
                                n_lpos = 8'd0;
                                n_lcnt = w_lnext[7:0];
                                if (w_lnext >= 9'(r_hdr[1])) begin
                                    n_phase = PH_DONE;
                                    n_rdx   = 8'd0;
                                    n_rdy   = 8'd0;
                                    w_res   = 1'b1;
                                    w_ok    = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            if (w_fail) begin
                n_phase = PH_FAILED;
                w_res   = 1'b1;
                w_ok    = 1'b0;
            end
        end else if (r_state == S_PAL) begin
            w_res  = 1'b1;
            w_kind = K_PIXEL;
            n_state = S_IDLE;
            if (9'(r_rdx) + 9'd1 < 9'(r_hdr[0])) begin
                n_rdx = r_rdx + 8'd1;
            end else begin
                n_rdx = 8'd0;
                n_rdy = (9'(r_rdy) + 9'd1 < 9'(r_hdr[1])) ? r_rdy + 8'd1 : 8'd0;
            end
        end
    end

    // a step that yields a result holds until the output register is free
    assign w_commit = !(w_res && w_busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HEADER;
            r_hdr   <= '{default: 8'd0};
            r_fcnt  <= 3'd0;
            r_innum <= 1'b0;
            r_lpos  <= 8'd0;
            r_lcnt  <= 8'd0;
            r_acc   <= 32'h0;
            r_csym  <= 8'd0;
            r_hex   <= 1'b0;
            r_mask  <= 3'd0;
            r_rdx   <= 8'd0;
            r_rdy   <= 8'd0;
            r_svld  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            // drained beat leaves the register unless a new result loads it
            if (o_out.ready && !w_res) r_ovld <= 1'b0;
            if (w_acc_in) begin
                r_func  <= i_in.func;
                r_byte  <= i_in.text_byte;
                r_state <= S_EXEC;
            end else if ((r_state != S_IDLE) && w_commit) begin
                r_state <= n_state;
                r_phase <= n_phase;
                r_hdr   <= n_hdr;
                r_fcnt  <= n_fcnt;
                r_innum <= n_innum;
                r_lpos  <= n_lpos;
                r_lcnt  <= n_lcnt;
                r_acc   <= n_acc;
                r_csym  <= n_csym;
                r_hex   <= n_hex;
                r_mask  <= n_mask;
                r_rdx   <= n_rdx;
                r_rdy   <= n_rdy;
                if (n_sclr) r_svld <= '0;
                else if (w_sym_we) r_svld[r_csym] <= 1'b1;
                if (w_res) begin
                    r_ovld  <= 1'b1;
                    r_okind <= w_kind;
                    r_ook   <= w_ok;
                    r_ocol  <= (w_kind == K_PIXEL) ? w_pal_q : 32'h0;
                    r_ox    <= (w_kind == K_PIXEL) ? r_rdx : 8'd0;
                    r_oy    <= (w_kind == K_PIXEL) ? r_rdy : 8'd0;
                    r_olast <= (w_kind == K_PIXEL) &&
                               (9'(r_rdx) + 9'd1 >= 9'(r_hdr[0])) &&
                               (9'(r_rdy) + 9'd1 >= 9'(r_hdr[1]));
                end
            end
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.kind        = r_okind;
    assign o_out.image_ok    = r_ook;
    assign o_out.pixel_color = r_ocol;
    assign o_out.pixel_x     = r_ox;
    assign o_out.pixel_y     = r_oy;
    assign o_out.last_pixel  = r_olast;

    // pixel results only come from a complete image
    a_pix_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAL) |-> (r_phase == PH_DONE))
        else $error("pixel read without a complete image");

    // read position stays inside the image
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_rdx < r_hdr[0]) && (r_rdy < r_hdr[1]))
        else $error("read position outside the image");

    // palette entries are only written below the declared color count
    a_pal_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pal_we && w_commit) |-> (r_lcnt < r_hdr[2]))
        else $error("palette write beyond color count");

    // the palette state is only ever left for the idle state
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAL) |=> (r_state == S_IDLE) || (r_state == S_PAL))
        else $error("palette stage left without finishing");
endmodule

// ===== verif/xtid_checker.sv =====
// checker for the xpm text image decoder: watches both channels, predicts and compares
`timescale 1ns / 1ps
module xtid_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xtid_in_if         i_in,
    xtid_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending
);
    import xtid_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PALETTE, PH_PIXELS, PH_DONE, PH_FAILED
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic        image_ok;
        logic [31:0] color;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        last;
    } t_result;

    t_result     result_q[$];
    logic [7:0]  sym_map[256];
    logic [31:0] palette[256];
    logic [7:0]  pix_map[65536];
    t_phase      phase;
    logic [7:0]  hdr[4];
    int          line_pos;
    int          line_cnt;
    logic [31:0] color_acc;
    logic [15:0] rd_pos;
    int          field_cnt;
    bit          in_num;
    logic [7:0]  cur_sym;
    bit          hex_mode;
    logic [2:0]  name_mask;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();

    function automatic string name_str(int i);
        case (i)
            0: return "None";
            1: return "Black";
            default: return "White";
        endcase
    endfunction

    function automatic logic [31:0] name_color(int i);
        case (i)
            0: return COLOR_NONE;
            1: return COLOR_BLACK;
            default: return COLOR_WHITE;
        endcase
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    task automatic clear_image();
        foreach (sym_map[i]) sym_map[i] = NO_SYMBOL;
        phase = PH_HEADER;
        foreach (hdr[i]) hdr[i] = 8'd0;
        line_pos = 0; line_cnt = 0; color_acc = 32'h0; rd_pos = 16'h0;
        field_cnt = 0; in_num = 0; cur_sym = 8'd0; hex_mode = 0; name_mask = 3'd0;
    endtask

    task automatic push_status(bit ok);
        t_result r;
        r = '0;
        r.kind = K_STATUS;
        r.image_ok = ok;
        if (!ok) phase = PH_FAILED;
        result_q.push_back(r);
    endtask

    task automatic filter_names(int k, logic [7:0] b);
        string s;
        for (int i = 0; i < 3; i++) begin
            s = name_str(i);
            if (name_mask[i] && (k >= s.len() || s[k] != b)) name_mask[i] = 1'b0;
        end
    endtask

    task automatic text_beat(logic [7:0] b);
        int v;
        int d;
        case (phase)
            PH_HEADER: begin
                if (b >= "0" && b <= "9") begin
                    if (!in_num) begin
                        if (field_cnt >= 4) begin
                            push_status(0);
                            return;
                        end
                        in_num = 1;
                        field_cnt++;
                    end
                    v = hdr[field_cnt-1] * 10 + (b - "0");
                    hdr[field_cnt-1] = (v > 255) ? 8'd255 : v[7:0];
                end else if (b == " " || (b >= 9 && b <= 13)) begin
                    in_num = 0;
                end else begin
                    push_status(0);
                end
            end
            PH_PALETTE: begin
                if (b == 0) begin
                    push_status(0);
                    return;
                end
                if (line_pos == 0) begin
                    if (sym_map[b] != NO_SYMBOL) begin
                        push_status(0);
                        return;
                    end
                    cur_sym = b;
                end else if (line_pos == 1 || line_pos == 3) begin
                    if (b != " ") begin
                        push_status(0);
                        return;
                    end
                end else if (line_pos == 2) begin
                    if (b != "c") begin
                        push_status(0);
                        return;
                    end
                end else if (line_pos == 4) begin
                    if (b == "#") begin
                        hex_mode = 1;
                        color_acc = 32'h0;
                    end else begin
                        hex_mode = 0;
                        name_mask = 3'b111;
                        filter_names(0, b);
                        if (name_mask == 0) begin
                            push_status(0);
                            return;
                        end
                    end
                end else if (hex_mode) begin
                    d = hex_digit(b);
                    if (line_pos > 12 || d < 0) begin
                        push_status(0);
                        return;
                    end
                    color_acc = {color_acc[27:0], d[3:0]};
                end else begin
                    filter_names(line_pos - 4, b);
                    if (name_mask == 0) begin
                        push_status(0);
                        return;
                    end
                end
                if (line_pos < 255) line_pos++;
            end
            PH_PIXELS: begin
                if (line_pos < hdr[0]) begin
                    if (sym_map[b] == NO_SYMBOL) begin
                        push_status(0);
                        return;
                    end
                    pix_map[{line_cnt[7:0], line_pos[7:0]}] = sym_map[b];
                    line_pos++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic eol_beat();
        logic [31:0] c;
        bit ok;
        string s;
        case (phase)
            PH_HEADER: begin
                in_num = 0;
                if (field_cnt != 4 || hdr[0] < 1 || hdr[0] > MAX_SIDE || hdr[1] < 1
                        || hdr[1] > MAX_SIDE || hdr[2] < 2 || hdr[2] > MAX_COLORS
                        || hdr[3] != 1) begin
                    push_status(0);
                end else begin
                    phase = PH_PALETTE;
                    line_cnt = 0;
                    line_pos = 0;
                end
            end
            PH_PALETTE: begin
                ok = 0;
                c = 32'h0;
                if (line_pos < 5) begin
                    push_status(0);
                    return;
                end
                if (hex_mode) begin
                    if (line_pos - 5 == 6 || line_pos - 5 == 8) begin
                        c = color_acc;
                        ok = 1;
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        s = name_str(i);
                        if (name_mask[i] && s.len() == line_pos - 4) begin
                            c = name_color(i);
                            ok = 1;
                        end
                    end
                end
                if (!ok) begin
                    push_status(0);
                    return;
                end
                palette[line_cnt[7:0]] = c;
                sym_map[cur_sym] = line_cnt[7:0];
                line_cnt++;
                line_pos = 0;
                if (line_cnt >= hdr[2]) begin
                    phase = PH_PIXELS;
                    line_cnt = 0;
                end
            end
            PH_PIXELS: begin
                if (line_pos < hdr[0]) begin
                    push_status(0);
                    return;
                end
                line_cnt++;
                line_pos = 0;
                if (line_cnt >= hdr[1]) begin
                    phase = PH_DONE;
                    rd_pos = 16'h0;
                    push_status(1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic read_beat();
        t_result r;
        int x;
        int y;
        r = '0;
        if (phase != PH_DONE) begin
            r.kind = K_REFUSED;
            result_q.push_back(r);
            return;
        end
        x = rd_pos[7:0];
        y = rd_pos[15:8];
        r.kind  = K_PIXEL;
        r.color = palette[pix_map[rd_pos]];
        r.x     = x[7:0];
        r.y     = y[7:0];
        r.last  = (x + 1 >= hdr[0]) && (y + 1 >= hdr[1]);
        result_q.push_back(r);
        if (x + 1 < hdr[0]) begin
            x++;
        end else begin
            x = 0;
            y = (y + 1 < hdr[1]) ? y + 1 : 0;
        end
        rd_pos = {y[7:0], x[7:0]};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_image();
            result_q.delete();
            fails = 0;
        end else begin
            // result side first: a beat's result can never appear in its own cycle
            if (i_out.valid && i_out.ready) begin
                t_result got;
                t_result exp_r;
                got.kind     = t_kind'(i_out.kind);
                got.image_ok = i_out.image_ok;
                got.color    = i_out.pixel_color;
                got.x        = i_out.pixel_x;
                got.y        = i_out.pixel_y;
                got.last     = i_out.last_pixel;
                if (result_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %p", $time, got);
                    fails++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (t_func'(i_in.func))
                    F_START: clear_image();
                    F_TEXT:  text_beat(i_in.text_byte);
                    F_EOL:   eol_beat();
                    default: read_beat();
                endcase
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// top of the decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
    import xtid_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   sent;

    xtid_in_if  in_ch();
    xtid_out_if out_ch();

    always #5 i_clk = ~i_clk;

    xpm_text_image_decoder dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    xtid_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = F_START;
        in_ch.text_byte = 8'd0;
        out_ch.ready = 1'b0;
    end

    // receiver stalls are drawn fresh every cycle
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one beat: optional random gap, then hold valid until taken
    task automatic send_beat(t_func f, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.text_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++) send_beat(F_TEXT, s[i]);
        send_beat(F_EOL, 8'd0);
    endtask

    task automatic send_reads(int n);
        repeat (n) send_beat(F_READ, 8'd0);
    endtask

    function automatic string rand_hex(int n);
        string s;
        string digits;
        digits = "0123456789abcdefABCDEF";
        s = "";
        repeat (n) s = {s, string'(digits[$urandom_range(21)])};
        return s;
    endfunction

    // random image: mostly well formed, sometimes broken on purpose
    task automatic random_image(int corrupt);
        int w, h, n;
        byte syms[$];
        string ln;
        byte c;
        w = ($urandom_range(15) == 0) ? $urandom_range(40, 254) : $urandom_range(1, 6);
        h = ($urandom_range(15) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 5);
        if (w > 40) h = 1;
        n = $urandom_range(2, 6);
        if ($urandom_range(30) == 0) n = $urandom_range(7, 32);
        send_beat(F_START, 8'($urandom));
        ln = $sformatf("%0d %0d\t%0d  1", w, h, n);
        if (corrupt == 1) ln = $sformatf("%0d %0d %0d %0d", w, h, n, $urandom_range(0, 3));
        send_line(ln);
        // symbols: distinct non-zero bytes
        while (syms.size() < n) begin
            c = byte'($urandom_range(1, 255));
            if (!(c inside {syms})) syms.push_back(c);
        end
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(4))
                0: ln = "None";
                1: ln = "Black";
                2: ln = "White";
                3: ln = {"#", rand_hex(6)};
                default: ln = {"#", rand_hex(8)};
            endcase
            if (corrupt == 2 && i == n - 1) ln = {"#", rand_hex($urandom_range(0, 9))};
            ln = {string'(syms[i]), " c ", ln};
            if (corrupt == 3 && i == n - 1) ln = {string'(syms[0]), ln.substr(1, ln.len()-1)};
            send_line(ln);
        end
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                // short last row: its final pixel is left out
                if (corrupt == 5 && y == h - 1 && x == w - 1) break;
                c = syms[$urandom_range(n - 1)];
                if (corrupt == 4 && y == h - 1 && x == w - 1) c = byte'($urandom);
                send_beat(F_TEXT, c);
            end
            if ($urandom_range(5) == 0) send_beat(F_TEXT, 8'($urandom));
            send_beat(F_EOL, 8'd0);
        end
        send_reads($urandom_range(1, 2 * w * h < 40 ? 2 * w * h + 2 : 40));
    endtask

    task automatic set_phase(int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    initial begin
        sent = 0;
        idle_cycles = 0;
        set_phase(0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: read with no image, smallest image, names, 8-digit hex, zero byte,
        // bad header char, fifth number, extra row bytes, unknown symbol
        send_reads(1);
        send_line("1 1 2 1");
        send_line("a c None");
        send_line("b c #FFffFFff");
        send_line("ab");
        send_reads(3);
        send_beat(F_EOL, 8'd0);
        send_beat(F_START, 8'd0);
        send_line("254 1 2 1 7");
        send_beat(F_START, 8'd0);
        send_line("2 x");
        send_beat(F_START, 8'd0);
        send_line("2 1 2 1");
        send_line("\001 c Black");
        send_line("\377 c #000000");
        send_beat(F_TEXT, 8'hff);
        send_beat(F_TEXT, 8'h00);
        send_beat(F_START, 8'd0);
        send_beat(F_TEXT, 8'h00);
        send_reads(1);

        for (int k = 0; sent < 1850 || k < 8; k++) begin
            set_phase(k / 6);
            random_image(($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/xtid_pkg.sv
sv/xtid_if.sv
sv/xtid_ram.sv
sv/xpm_text_image_decoder.sv
verif/xtid_checker.sv
verif/tb_top.sv
